// ===== rtl/core/form_urlencoded_parser_assert.svh =====
// Assertion macros for the form body decoder.
// Included by the top level; relies on clk and arst_n being in scope.
`ifndef FORM_URLENCODED_PARSER_ASSERT_SVH
`define FORM_URLENCODED_PARSER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FUP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FUP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fup_pkg.sv =====
// Shared types, character constants and the hex digit rule of the decoder.
// No dependencies.
package fup_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	localparam logic [7:0] CH_PLUS        = 8'h2b;
	localparam logic [7:0] CH_PCT         = 8'h25;
	localparam logic [7:0] CH_AMP         = 8'h26;
	localparam logic [7:0] CH_EQ          = 8'h3d;
	localparam logic [7:0] CH_SPACE       = 8'h20;
	localparam logic [7:0] CH_ZERO        = 8'h30;
	localparam logic [7:0] CH_UPPER_A     = 8'h41;
	localparam logic [7:0] HEX_CASE_MASK  = 8'hdf;
	localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

	typedef enum logic [1:0] {
		KIND_NAME  = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ESC_IDLE = 3'b001,
		ESC_HI   = 3'b010,
		ESC_LO   = 3'b100
	} esc_t;

	typedef struct packed {
		logic       has_data;
		logic       is_value;
		logic [7:0] data;
		logic       has_end;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// Unchecked digit rule: a plus counts as a space, result wraps to 8 bits.
	function automatic logic [7:0] hex_digit(input logic [7:0] c);
		logic [7:0] ch;
		ch = (c == CH_PLUS) ? CH_SPACE : c;
		if (ch >= CH_UPPER_A) begin
			return (ch & HEX_CASE_MASK) - CH_UPPER_A + HEX_ALPHA_BASE;
		end
		return ch - CH_ZERO;
	endfunction

endpackage

// ===== rtl/core/fup_stream_if.sv =====
// Valid/ready channel interfaces for raw body bytes and decoded tokens.
// Depends on fup_pkg.
interface fup_body_if;
	logic       valid;
	logic       ready;
	logic [7:0] raw_byte;
	logic       body_end;

	modport source (output valid, output raw_byte, output body_end, input ready);
	modport sink (input valid, input raw_byte, input body_end, output ready);
endinterface

interface fup_token_if import fup_pkg::*; ;
	logic       valid;
	logic       ready;
	kind_t      kind;
	logic [7:0] data;
	logic       run_last;

	modport source (output valid, output kind, output data, output run_last, input ready);
	modport sink (input valid, input kind, input data, input run_last, output ready);
endinterface

// ===== rtl/core/fup_front.sv =====
// Front end: accepts raw bytes, tracks escape and name/value state, and
// issues one queue command per byte that gives any result. Depends on fup_pkg.
module fup_front import fup_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	fup_body_if.sink      body,
	input  fifo_stat_t    qstat,
	output logic          push,
	output cmd_t          cmd
);

	esc_t       esc_q, esc_d;
	logic [3:0] high_q, high_d;
	logic       val_q, val_d;
	logic       is_amp;
	logic       dec_vld;
	logic [7:0] dec_b;
	logic [7:0] digit;
	logic       accept;

	assign body.ready = !qstat.full;
	assign accept     = body.valid && body.ready;
	assign digit      = hex_digit(body.raw_byte);

	always_comb begin
		is_amp  = (body.raw_byte == CH_AMP);
		dec_vld = 1'b0;
		dec_b   = '0;
		esc_d   = esc_q;
		high_d  = high_q;
		val_d   = val_q;
		cmd     = '0;
		if (!is_amp) begin
			unique case (esc_q)
				ESC_HI: begin
					high_d = digit[3:0];
					esc_d  = ESC_LO;
				end
				ESC_LO: begin
					dec_b   = {high_q, 4'h0} + digit;
					dec_vld = 1'b1;
					esc_d   = ESC_IDLE;
					high_d  = '0;
				end
				default: begin
					if (body.raw_byte == CH_PCT) begin
						esc_d  = ESC_HI;
						high_d = '0;
					end else begin
						dec_b   = (body.raw_byte == CH_PLUS) ? CH_SPACE : body.raw_byte;
						dec_vld = 1'b1;
						esc_d   = ESC_IDLE;
					end
				end
			endcase
		end
		if (dec_vld) begin
			if (!val_q && dec_b == CH_EQ) begin
				val_d = 1'b1;
			end else begin
				cmd.has_data = 1'b1;
				cmd.is_value = val_q;
				cmd.data     = dec_b;
			end
		end
		if (is_amp || body.body_end) begin
			cmd.has_end = 1'b1;
			esc_d       = ESC_IDLE;
			high_d      = '0;
			val_d       = 1'b0;
		end
	end

	assign push = accept && (cmd.has_data || cmd.has_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q  <= ESC_IDLE;
			high_q <= '0;
			val_q  <= 1'b0;
		end else if (accept) begin
			esc_q  <= esc_d;
			high_q <= high_d;
			val_q  <= val_d;
		end
	end

endmodule

// ===== rtl/core/fup_queue.sv =====
// Short command queue between the front and back ends.
// Depends on fup_pkg.
module fup_queue import fup_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmd_t       push_data,
	input  logic       pop,
	output cmd_t       pop_data,
	output fifo_stat_t stat
);

	localparam logic [FIFO_CW-1:0] FIFO_FULL = FIFO_CW'(FIFO_DEPTH);

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full  = (cnt_q == FIFO_FULL);
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/fup_back.sv =====
// Back end: expands each queue command into one or two tokens and holds
// them in the output register. Depends on fup_pkg and fup_token_if.
module fup_back import fup_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         head,
	input  logic         head_valid,
	output logic         pop,
	fup_token_if.source  token
);

	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] data_q;
	logic       last_q;
	logic       half_q, half_d;
	logic       load;
	logic       emit;
	kind_t      kind_d;
	logic [7:0] data_d;
	logic       last_d;

	assign load = !out_valid_q || token.ready;

	always_comb begin
		pop    = 1'b0;
		emit   = 1'b0;
		half_d = half_q;
		kind_d = KIND_END;
		data_d = '0;
		last_d = 1'b1;
		if (load && head_valid) begin
			emit = 1'b1;
			if (head.has_data && !half_q) begin
				kind_d = head.is_value ? KIND_VALUE : KIND_NAME;
				data_d = head.data;
				last_d = !head.has_end;
				if (head.has_end) begin
					half_d = 1'b1;
				end else begin
					pop = 1'b1;
				end
			end else begin
				pop    = 1'b1;
				half_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q      <= 1'b0;
		end else begin
			half_q <= half_d;
			if (load) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= kind_d;
			data_q <= data_d;
			last_q <= last_d;
		end
	end

	assign token.valid    = out_valid_q;
	assign token.kind     = kind_q;
	assign token.data     = data_q;
	assign token.run_last = last_q;

endmodule

// ===== rtl/core/form_urlencoded_parser.sv =====
// Top level of the form body decoder: front end, command queue, back end.
// Depends on fup_pkg, fup_stream_if, fup_front, fup_queue, fup_back and the assertion header.
//
//   Channel  Side    Transaction payload
//   body     sink    raw_byte[7:0], body_end
//   token    source  kind[1:0], data[7:0], run_last
//
// One body byte is taken every cycle while the command queue has room.
// The back end drives one token per cycle while the token side is ready, so a byte that gives a
// data token and an end token takes two output transfers; the output register sets that rate.
// A token passes through the command queue and then the output register after its byte is taken.
// Reset is asynchronous and clears the escape state, the queue count and pointers and the output valid flag.
// A stalled token side fills the four-entry queue before body stops being accepted.
`include "form_urlencoded_parser_assert.svh"

module form_urlencoded_parser import fup_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	fup_body_if.sink     body,
	fup_token_if.source  token
);

	cmd_t       push_cmd;
	cmd_t       head_cmd;
	logic       push;
	logic       pop;
	fifo_stat_t qstat;

	fup_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body),
		.qstat  (qstat),
		.push   (push),
		.cmd    (push_cmd)
	);

	fup_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.pop       (pop),
		.pop_data  (head_cmd),
		.stat      (qstat)
	);

	fup_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_cmd),
		.head_valid (!qstat.empty),
		.pop        (pop),
		.token      (token)
	);

	`FUP_ASSERT_SAME(a_queue_stat, 1'b1, !(qstat.full && qstat.empty), "queue full and empty")
	`FUP_ASSERT_SAME(a_end_token, token.valid && token.kind == KIND_END, token.data == 8'h00 && token.run_last, "malformed end token")
	`FUP_ASSERT_NEXT(a_end_follows, token.valid && token.ready && !token.run_last, token.valid && token.kind == KIND_END, "end token missing after data")
	`FUP_ASSERT_SAME(a_no_push_full, push, !qstat.full, "push into full queue")

endmodule

// ===== tb/form_urlencoded_parser_checker.sv =====
`timescale 1ns / 100ps
// Transaction checker for the form body decoder: watches both channels, predicts the tokens
// of every accepted body byte and compares them in order. Depends on fup_pkg.
module form_urlencoded_parser_checker import fup_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       body_valid,
	input  logic       body_ready,
	input  logic [7:0] raw_byte,
	input  logic       body_end,
	input  logic       token_valid,
	input  logic       token_ready,
	input  kind_t      kind,
	input  logic [7:0] data,
	input  logic       run_last,
	output int         failures,
	output int         pending
);

	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		logic       run_last;
	} token_exp_t;

	token_exp_t expected_tokens[$];

	logic       in_value;
	esc_t       esc;
	logic [7:0] high_part;
	int         fail_cnt;

	function automatic logic [7:0] digit_of(input logic [7:0] c);
		logic [7:0] ch;
		ch = (c == CH_PLUS) ? CH_SPACE : c;
		if (ch < CH_UPPER_A) begin
			return ch - CH_ZERO;
		end
		return (ch & HEX_CASE_MASK) - (CH_UPPER_A - HEX_ALPHA_BASE);
	endfunction

	task automatic decode_byte(input logic [7:0] c, input logic last);
		logic [7:0] b;
		logic       have_b;
		int         first;
		have_b = 1'b0;
		b      = 8'h00;
		first  = expected_tokens.size();
		if (c != CH_AMP) begin
			case (esc)
				ESC_HI: begin
					high_part = digit_of(c);
					esc       = ESC_LO;
				end
				ESC_LO: begin
					b         = {high_part[3:0], 4'h0} + digit_of(c);
					esc       = ESC_IDLE;
					high_part = 8'h00;
					have_b    = 1'b1;
				end
				default: begin
					if (c == CH_PCT) begin
						esc       = ESC_HI;
						high_part = 8'h00;
					end else begin
						esc    = ESC_IDLE;
						b      = (c == CH_PLUS) ? CH_SPACE : c;
						have_b = 1'b1;
					end
				end
			endcase
			if (have_b) begin
				if (!in_value && b == CH_EQ) begin
					in_value = 1'b1;
				end else begin
					expected_tokens.push_back('{in_value ? KIND_VALUE : KIND_NAME, b, 1'b0});
				end
			end
		end
		if (c == CH_AMP || last) begin
			expected_tokens.push_back('{KIND_END, 8'h00, 1'b0});
			in_value  = 1'b0;
			esc       = ESC_IDLE;
			high_part = 8'h00;
		end
		if (expected_tokens.size() > first) begin
			expected_tokens[expected_tokens.size() - 1].run_last = 1'b1;
		end
	endtask

	task automatic compare_token();
		token_exp_t want;
		if (expected_tokens.size() == 0) begin
			fail_cnt++;
			if (fail_cnt <= 10) begin
				$display("%0t: unexpected token kind %0d data %02h run_last %b",
					$realtime, kind, data, run_last);
			end
		end else begin
			want = expected_tokens.pop_front();
			if (kind !== want.kind || data !== want.data || run_last !== want.run_last) begin
				fail_cnt++;
				if (fail_cnt <= 10) begin
					$display("%0t: token mismatch: expected kind %0d data %02h run_last %b, got kind %0d data %02h run_last %b",
						$realtime, want.kind, want.data, want.run_last, kind, data, run_last);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_tokens.delete();
			in_value  = 1'b0;
			esc       = ESC_IDLE;
			high_part = 8'h00;
			fail_cnt  = 0;
			failures <= 0;
			pending  <= 0;
		end else begin
			if (body_valid && body_ready) begin
				decode_byte(raw_byte, body_end);
			end
			if (token_valid && token_ready) begin
				compare_token();
			end
			failures <= fail_cnt;
			pending  <= expected_tokens.size();
		end
	end

endmodule

// ===== tb/form_urlencoded_parser_tb.sv =====
`timescale 1ns / 100ps
// Top of the form body decoder testbench: clock, reset, body stimulus and token back-pressure.
// Depends on fup_pkg, fup_stream_if, form_urlencoded_parser and the transaction checker.
module form_urlencoded_parser_tb;
	import fup_pkg::*;

	typedef struct {
		logic [7:0] raw;
		logic       last;
	} body_beat_t;

	logic clk;
	logic arst_n;

	fup_body_if  body();
	fup_token_if token();

	int failures;
	int pending;

	body_beat_t byte_q[$];
	int         sent_cnt;
	bit         calm;
	bit         stall_req;
	bit         stall_done;
	bit         paused;

	form_urlencoded_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body),
		.token  (token)
	);

	form_urlencoded_parser_checker u_token_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.body_valid  (body.valid),
		.body_ready  (body.ready),
		.raw_byte    (body.raw_byte),
		.body_end    (body.body_end),
		.token_valid (token.valid),
		.token_ready (token.ready),
		.kind        (token.kind),
		.data        (token.data),
		.run_last    (token.run_last),
		.failures    (failures),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		token.ready = 1'b0;
		stall_done  = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req && !stall_done) begin
				token.ready <= 1'b0;
				repeat (200) @(posedge clk);
				stall_done = 1'b1;
			end else if (!calm && $urandom_range(0, 99) < 10) begin
				token.ready <= 1'b0;
			end else begin
				token.ready <= 1'b1;
			end
		end
	end

	function automatic logic [7:0] any_but_amp();
		logic [7:0] b;
		b = 8'($urandom_range(0, 254));
		if (b >= CH_AMP) begin
			b = b + 8'd1;
		end
		return b;
	endfunction

	function automatic logic [7:0] hex_char();
		int r;
		r = $urandom_range(0, 29);
		if (r < 10) begin
			return CH_ZERO + 8'(r);
		end else if (r < 16) begin
			return CH_UPPER_A + 8'(r - 10);
		end else if (r < 22) begin
			return (CH_UPPER_A | ~HEX_CASE_MASK) + 8'(r - 16);
		end else if (r < 25) begin
			return CH_PLUS;
		end
		return any_but_amp();
	endfunction

	task automatic queue_byte(input logic [7:0] raw, input logic last = 1'b0);
		byte_q.push_back('{raw, last});
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			queue_byte(s[i]);
		end
	endtask

	task automatic close_body();
		byte_q[byte_q.size() - 1].last = 1'b1;
	endtask

	task automatic queue_text_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			queue_byte(8'($urandom_range(8'h61, 8'h7a)));
		end else if (r < 65) begin
			queue_byte(CH_PLUS);
		end else if (r < 85) begin
			queue_byte(CH_PCT);
			if ($urandom_range(0, 19) == 0) begin
				queue_text("3D");
			end else begin
				queue_byte(hex_char());
				queue_byte(hex_char());
			end
		end else if (r < 92) begin
			queue_byte(CH_EQ);
		end else begin
			queue_byte(any_but_amp());
		end
	endtask

	task automatic queue_entry(input bit ends_body);
		int n_name;
		int n_val;
		n_name = $urandom_range(0, 6);
		n_val  = $urandom_range(0, 8);
		repeat (n_name) queue_text_char();
		if ($urandom_range(0, 9) != 0) begin
			queue_byte(CH_EQ);
		end
		repeat (n_val) queue_text_char();
		if ($urandom_range(0, 9) == 0) begin
			queue_byte(CH_PCT);
			if ($urandom_range(0, 1) == 1) begin
				queue_byte(hex_char());
			end
		end
		if (ends_body) begin
			if (byte_q.size() == 0) begin
				queue_text_char();
			end
			close_body();
		end else begin
			queue_byte(CH_AMP);
		end
	endtask

	task automatic put_byte(input logic [7:0] raw, input logic last);
		calm = (sent_cnt >= 400 && sent_cnt < 600);
		if (!calm && $urandom_range(0, 99) < 10) begin
			body.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 30);
		end
		body.valid    <= 1'b1;
		body.raw_byte <= raw;
		body.body_end <= last;
		do @(posedge clk); while (!body.ready);
		sent_cnt++;
	endtask

	task automatic send_bytes();
		body_beat_t beat;
		while (byte_q.size() > 0) begin
			beat = byte_q.pop_front();
			put_byte(beat.raw, beat.last);
		end
	endtask

	task automatic wait_for_tokens();
		body.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		arst_n        = 1'b0;
		body.valid    = 1'b0;
		body.raw_byte = 8'h00;
		body.body_end = 1'b0;
		sent_cnt      = 0;
		calm          = 1'b0;
		stall_req     = 1'b0;
		paused        = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Separator, decoded separator, plus as a digit, extremes, cut escapes, empty entry.
		queue_text("n=v&%3Dx=y");
		close_body();
		queue_text("+%+a=");
		queue_byte(8'hff);
		queue_byte(8'h00);
		queue_text("%Ff%4&%");
		close_body();
		queue_text("&");
		send_bytes();

		while (sent_cnt < 1825) begin
			if (!stall_req && sent_cnt >= 900) begin
				stall_req = 1'b1;
			end
			if (!paused && sent_cnt >= 1300) begin
				paused = 1'b1;
				wait_for_tokens();
			end
			if ($urandom_range(0, 99) < 85) begin
				queue_entry($urandom_range(0, 3) == 0);
			end else begin
				repeat ($urandom_range(1, 6)) begin
					queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
				end
			end
			send_bytes();
		end

		wait_for_tokens();
		repeat (20) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/fup_pkg.sv
rtl/core/fup_stream_if.sv
rtl/core/fup_front.sv
rtl/core/fup_queue.sv
rtl/core/fup_back.sv
rtl/core/form_urlencoded_parser.sv
tb/form_urlencoded_parser_checker.sv
tb/form_urlencoded_parser_tb.sv
